[rtl/imvc_pkg.sv]
// Package for the image marker version checker.
// Holds payload structs, enums, register indexes and marker text tables.
// No dependencies.
`default_nettype none

package imvc_pkg;

   localparam int CAPTURE_MAX_DEF = 96;
   localparam int ID_MAX_DEF      = 24;
   localparam int SUFFIX_MAX_DEF  = 8;

   localparam int PREFIX_LEN = 9;
   localparam int SUFFIX_LEN = 10;
   localparam logic [15:0] NUM_SAT = 16'hFFFF;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [2:0] REG_ID_WORD0   = 3'd0;
   localparam logic [2:0] REG_ID_WORD1   = 3'd1;
   localparam logic [2:0] REG_ID_WORD2   = 3'd2;
   localparam logic [2:0] REG_ID_LENGTH  = 3'd3;
   localparam logic [2:0] REG_OWN_VER    = 3'd4;
   localparam logic [2:0] REG_OWN_SFX    = 3'd5;
   localparam logic [2:0] REG_OWN_SFX_LEN = 3'd6;
   localparam logic [2:0] REG_ALLOW_DOWN = 3'd7;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic marker_found;
      logic identity_match;
      logic version_allowed;
      logic image_accepted;
   } rsp_type;

   typedef enum logic {ST_SCAN, ST_EVAL} state_type;
   typedef enum logic [1:0] {PH_ID, PH_CORE, PH_SFX} phase_type;
   typedef enum logic [1:0] {PM_WS, PM_DIG, PM_DONE} pmode_type;
   typedef enum logic [1:0] {ORD_EQ, ORD_GT, ORD_LT} ord_type;

   function automatic logic [7:0] prefix_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0: c = "S";
         4'd1: c = "M";
         4'd2: c = "-";
         4'd3: c = "F";
         4'd4: c = "W";
         4'd5: c = "-";
         4'd6: c = "I";
         4'd7: c = "D";
         4'd8: c = ":";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // all ten suffix characters, oldest first
   function automatic logic [7:0] suffix_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0: c = ":";
         4'd1: c = "S";
         4'd2: c = "M";
         4'd3: c = "-";
         4'd4: c = "F";
         4'd5: c = "W";
         4'd6: c = "-";
         4'd7: c = "E";
         4'd8: c = "N";
         4'd9: c = "D";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [15:0] dec_acc(input logic [15:0] v, input logic [7:0] c);
      logic [19:0] t;
      t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'h0000, c[3:0] - CH_ZERO[3:0]};
      return (t > {4'h0, NUM_SAT}) ? NUM_SAT : t[15:0];
   endfunction

endpackage

`default_nettype wire

[rtl/image_marker_version_checker.sv]
// Top level of the image marker version checker: scanner, capture memory,
// payload evaluation sequencer and register port. Uses imvc_pkg.
// One result transfer per input transfer.
`default_nettype none

// Each image byte or new-image command yields one result holding the flags
// after that byte. The byte that completes the end marker starts an
// evaluation pass that reads the capture memory one entry a cycle (synchronous
// read port); input is stalled during the pass. Once a marker with a colon is
// found, bytes are ignored until the next new-image command.
module image_marker_version_checker #(
   parameter int CAPTURE_MAX = imvc_pkg::CAPTURE_MAX_DEF,
   parameter int ID_MAX      = imvc_pkg::ID_MAX_DEF,
   parameter int SUFFIX_MAX  = imvc_pkg::SUFFIX_MAX_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire imvc_pkg::req_type            req_data,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output imvc_pkg::rsp_type                 rsp_data,
   input  wire                               psel,
   input  wire                               penable,
   input  wire                               pwrite,
   input  wire [imvc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire [imvc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [imvc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   localparam int CW = $clog2(CAPTURE_MAX + 1);
   localparam int AW = $clog2(CAPTURE_MAX);

   // registers
   logic [63:0] id_w0_ff, id_w1_ff, id_w2_ff, own_sfx_ff;
   logic [4:0]  id_len_ff;
   logic [47:0] own_ver_ff;
   logic [3:0]  own_sfx_len_ff;
   logic        allow_ff;

   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[5:3];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         id_w0_ff       <= '0;
         id_w1_ff       <= '0;
         id_w2_ff       <= '0;
         id_len_ff      <= '0;
         own_ver_ff     <= '0;
         own_sfx_ff     <= '0;
         own_sfx_len_ff <= '0;
         allow_ff       <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            imvc_pkg::REG_ID_WORD0:    id_w0_ff       <= pwdata;
            imvc_pkg::REG_ID_WORD1:    id_w1_ff       <= pwdata;
            imvc_pkg::REG_ID_WORD2:    id_w2_ff       <= pwdata;
            imvc_pkg::REG_ID_LENGTH:   id_len_ff      <= pwdata[4:0];
            imvc_pkg::REG_OWN_VER:     own_ver_ff     <= pwdata[47:0];
            imvc_pkg::REG_OWN_SFX:     own_sfx_ff     <= pwdata;
            imvc_pkg::REG_OWN_SFX_LEN: own_sfx_len_ff <= pwdata[3:0];
            imvc_pkg::REG_ALLOW_DOWN:  allow_ff       <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         imvc_pkg::REG_ID_WORD0:    prdata = id_w0_ff;
         imvc_pkg::REG_ID_WORD1:    prdata = id_w1_ff;
         imvc_pkg::REG_ID_WORD2:    prdata = id_w2_ff;
         imvc_pkg::REG_ID_LENGTH:   prdata = {59'd0, id_len_ff};
         imvc_pkg::REG_OWN_VER:     prdata = {16'd0, own_ver_ff};
         imvc_pkg::REG_OWN_SFX:     prdata = own_sfx_ff;
         imvc_pkg::REG_OWN_SFX_LEN: prdata = {60'd0, own_sfx_len_ff};
         imvc_pkg::REG_ALLOW_DOWN:  prdata = {63'd0, allow_ff};
         default:                   prdata = '0;
      endcase
   end

   // scan state
   imvc_pkg::state_type state_ff, state_in;
   logic [3:0]    pcnt_ff, pcnt_in;
   logic          capt_ff, capt_in;
   logic [CW-1:0] ccnt_ff, ccnt_in;
   logic          found_ff, found_in, idf_ff, idf_in, verf_ff, verf_in;
   logic [7:0]    hist_ff [0:imvc_pkg::SUFFIX_LEN-2];
   logic          rsp_valid_ff;
   imvc_pkg::rsp_type rsp_ff;

   logic          accept, wr_en, go_eval, sfx_hit, eval_done, load_rsp;
   logic [3:0]    pnext;
   logic [7:0]    b;

   // evaluation state
   logic [7:0]    mem [0:CAPTURE_MAX-1];
   logic [7:0]    rd_data_ff;
   logic [CW-1:0] len_ff, issue_ff, proc_ff;
   logic          dv_ff;
   imvc_pkg::phase_type ph_ff, ph_in;
   logic          idok_ff, idok_in, colon_ff, colon_in, idm_ff, idm_in;
   logic [1:0]    seg_ff, seg_in;
   imvc_pkg::pmode_type pm_ff, pm_in;
   logic [15:0]   num_ff [0:2];
   logic [15:0]   num_in [0:2];
   imvc_pkg::ord_type ord_ff, ord_in;
   logic [3:0]    scnt_ff, scnt_in;

   assign b      = req_data.data_byte;
   assign accept = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         imvc_pkg::ST_SCAN: if (accept && go_eval) state_in = imvc_pkg::ST_EVAL;
         imvc_pkg::ST_EVAL: if (eval_done) state_in = imvc_pkg::ST_SCAN;
         default:           state_in = imvc_pkg::ST_SCAN;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = 1'b1;
      eval_done = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         imvc_pkg::ST_SCAN: begin
            req_stall = rsp_valid_ff && rsp_stall;
            load_rsp  = accept && !go_eval;
         end
         imvc_pkg::ST_EVAL: begin
            eval_done = (issue_ff == len_ff) && !dv_ff;
            load_rsp  = eval_done;
         end
         default: ;
      endcase
   end

   always_comb begin
      sfx_hit = (ccnt_ff >= CW'(imvc_pkg::SUFFIX_LEN - 1))
         && (b == imvc_pkg::suffix_char(4'(imvc_pkg::SUFFIX_LEN - 1)));
      for (int i = 0; i < imvc_pkg::SUFFIX_LEN - 1; i++) begin
         if (hist_ff[i] != imvc_pkg::suffix_char(4'(i))) sfx_hit = 1'b0;
      end
   end

   // version compare at the end of the pass
   logic [15:0] mj, mn, pt;
   logic [3:0]  own_len;
   imvc_pkg::ord_type vord;

   always_comb begin
      mj = (seg_ff == 2'd2) ? num_ff[0] : 16'd0;
      mn = (seg_ff == 2'd2) ? num_ff[1] : 16'd0;
      pt = (seg_ff == 2'd2) ? num_ff[2] : 16'd0;
      own_len = (own_sfx_len_ff > 4'(SUFFIX_MAX)) ? 4'(SUFFIX_MAX) : own_sfx_len_ff;
      if (mj != own_ver_ff[47:32]) begin
         vord = (mj > own_ver_ff[47:32]) ? imvc_pkg::ORD_GT : imvc_pkg::ORD_LT;
      end else if (mn != own_ver_ff[31:16]) begin
         vord = (mn > own_ver_ff[31:16]) ? imvc_pkg::ORD_GT : imvc_pkg::ORD_LT;
      end else if (pt != own_ver_ff[15:0]) begin
         vord = (pt > own_ver_ff[15:0]) ? imvc_pkg::ORD_GT : imvc_pkg::ORD_LT;
      end else if (scnt_ff == 4'd0 && own_len != 4'd0) begin
         vord = imvc_pkg::ORD_GT;
      end else if (scnt_ff != 4'd0 && own_len == 4'd0) begin
         vord = imvc_pkg::ORD_LT;
      end else if (ord_ff != imvc_pkg::ORD_EQ) begin
         vord = ord_ff;
      end else if (scnt_ff != own_len) begin
         vord = (scnt_ff > own_len) ? imvc_pkg::ORD_GT : imvc_pkg::ORD_LT;
      end else begin
         vord = imvc_pkg::ORD_EQ;
      end
   end

   // scanner
   always_comb begin
      pcnt_in = pcnt_ff;
      capt_in = capt_ff;
      ccnt_in = ccnt_ff;
      found_in = found_ff;
      idf_in  = idf_ff;
      verf_in = verf_ff;
      wr_en   = 1'b0;
      go_eval = 1'b0;
      pnext   = '0;
      if (accept) begin
         if (!req_data.kind) begin
            pcnt_in = '0;
            capt_in = 1'b0;
            ccnt_in = '0;
            found_in = 1'b0;
            idf_in  = 1'b0;
            verf_in = 1'b0;
         end else if (!found_ff) begin
            if (!capt_ff) begin
               if (b == imvc_pkg::prefix_char(pcnt_ff)) begin
                  pnext = pcnt_ff + 4'd1;
               end else begin
                  pnext = (b == imvc_pkg::prefix_char(4'd0)) ? 4'd1 : 4'd0;
               end
               if (pnext >= 4'(imvc_pkg::PREFIX_LEN)) begin
                  pcnt_in = '0;
                  capt_in = 1'b1;
                  ccnt_in = '0;
               end else begin
                  pcnt_in = pnext;
               end
            end else if (sfx_hit) begin
               capt_in = 1'b0;
               ccnt_in = '0;
               go_eval = 1'b1;
            end else if (ccnt_ff >= CW'(CAPTURE_MAX)) begin
               capt_in = 1'b0;
               ccnt_in = '0;
            end else begin
               wr_en   = 1'b1;
               ccnt_in = ccnt_ff + CW'(1);
            end
         end
      end
      if (eval_done && colon_ff) begin
         found_in = 1'b1;
         idf_in   = idm_ff;
         verf_in  = allow_ff || (vord != imvc_pkg::ORD_LT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imvc_pkg::ST_SCAN;
         pcnt_ff      <= '0;
         capt_ff      <= 1'b0;
         ccnt_ff      <= '0;
         found_ff     <= 1'b0;
         idf_ff       <= 1'b0;
         verf_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pcnt_ff  <= pcnt_in;
         capt_ff  <= capt_in;
         ccnt_ff  <= ccnt_in;
         found_ff <= found_in;
         idf_ff   <= idf_in;
         verf_ff  <= verf_in;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff.marker_found    <= found_in;
         rsp_ff.identity_match  <= idf_in;
         rsp_ff.version_allowed <= verf_in;
         rsp_ff.image_accepted  <= found_in && idf_in && verf_in;
      end
      if (wr_en) begin
         for (int i = 0; i < imvc_pkg::SUFFIX_LEN - 2; i++) hist_ff[i] <= hist_ff[i+1];
         hist_ff[imvc_pkg::SUFFIX_LEN-2] <= b;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // capture memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[ccnt_ff[AW-1:0]] <= b;
      rd_data_ff <= mem[issue_ff[AW-1:0]];
   end

   // payload walk, one byte per cycle
   logic [7:0] c, idc, osc;
   logic       is_dig, is_ws;

   always_comb begin
      c = rd_data_ff;
      unique case (proc_ff[4:3])
         2'd0:    idc = id_w0_ff[8*proc_ff[2:0] +: 8];
         2'd1:    idc = id_w1_ff[8*proc_ff[2:0] +: 8];
         default: idc = id_w2_ff[8*proc_ff[2:0] +: 8];
      endcase
      osc    = own_sfx_ff[8*scnt_ff[2:0] +: 8];
      is_dig = (c >= imvc_pkg::CH_ZERO) && (c <= imvc_pkg::CH_NINE);
      is_ws  = (c == imvc_pkg::CH_SPACE) || ((c >= imvc_pkg::CH_TAB) && (c <= imvc_pkg::CH_CR));
      ph_in    = ph_ff;
      idok_in  = idok_ff;
      colon_in = colon_ff;
      idm_in   = idm_ff;
      seg_in   = seg_ff;
      pm_in    = pm_ff;
      num_in   = num_ff;
      ord_in   = ord_ff;
      scnt_in  = scnt_ff;
      if (dv_ff) begin
         case (ph_ff)
            imvc_pkg::PH_ID: begin
               if (c == imvc_pkg::CH_COLON) begin
                  colon_in = 1'b1;
                  idm_in = idok_ff && (id_len_ff <= 5'(ID_MAX))
                     && (proc_ff == CW'(id_len_ff));
                  ph_in = imvc_pkg::PH_CORE;
               end else if (proc_ff >= CW'(ID_MAX) || c != idc) begin
                  idok_in = 1'b0;
               end
            end
            imvc_pkg::PH_CORE: begin
               if (c == imvc_pkg::CH_DASH) begin
                  ph_in = imvc_pkg::PH_SFX;
               end else if (c == imvc_pkg::CH_DOT && seg_ff != 2'd2) begin
                  seg_in = seg_ff + 2'd1;
                  pm_in  = imvc_pkg::PM_WS;
               end else begin
                  case (pm_ff)
                     imvc_pkg::PM_WS: begin
                        if (is_ws) begin
                           pm_in = imvc_pkg::PM_WS;
                        end else if (c == imvc_pkg::CH_PLUS) begin
                           pm_in = imvc_pkg::PM_DIG;
                        end else if (is_dig) begin
                           num_in[seg_ff] = imvc_pkg::dec_acc(num_ff[seg_ff], c);
                           pm_in = imvc_pkg::PM_DIG;
                        end else begin
                           pm_in = imvc_pkg::PM_DONE;
                        end
                     end
                     imvc_pkg::PM_DIG: begin
                        if (is_dig) num_in[seg_ff] = imvc_pkg::dec_acc(num_ff[seg_ff], c);
                        else pm_in = imvc_pkg::PM_DONE;
                     end
                     default: ;
                  endcase
               end
            end
            default: begin
               if (ord_ff == imvc_pkg::ORD_EQ && scnt_ff < own_len && c != osc) begin
                  ord_in = (c > osc) ? imvc_pkg::ORD_GT : imvc_pkg::ORD_LT;
               end
               if (scnt_ff != 4'd9) scnt_in = scnt_ff + 4'd1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff    <= 1'b0;
         issue_ff <= '0;
         len_ff   <= '0;
      end else if (accept && go_eval) begin
         dv_ff    <= 1'b0;
         issue_ff <= '0;
         len_ff   <= ccnt_ff - CW'(imvc_pkg::SUFFIX_LEN - 1);
      end else if (state_ff == imvc_pkg::ST_EVAL) begin
         dv_ff <= issue_ff != len_ff;
         if (issue_ff != len_ff) issue_ff <= issue_ff + CW'(1);
      end else begin
         dv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && go_eval) begin
         proc_ff  <= '0;
         ph_ff    <= imvc_pkg::PH_ID;
         idok_ff  <= 1'b1;
         colon_ff <= 1'b0;
         idm_ff   <= 1'b0;
         seg_ff   <= '0;
         pm_ff    <= imvc_pkg::PM_WS;
         num_ff   <= '{default: '0};
         ord_ff   <= imvc_pkg::ORD_EQ;
         scnt_ff  <= '0;
      end else begin
         if (dv_ff) proc_ff <= proc_ff + CW'(1);
         ph_ff    <= ph_in;
         idok_ff  <= idok_in;
         colon_ff <= colon_in;
         idm_ff   <= idm_in;
         seg_ff   <= seg_in;
         pm_ff    <= pm_in;
         num_ff   <= num_in;
         ord_ff   <= ord_in;
         scnt_ff  <= scnt_in;
      end
   end

   a_stall_in_eval: assert property (@(posedge clock) disable iff (reset)
      state_ff == imvc_pkg::ST_EVAL |-> req_stall)
      else $error("input taken during evaluation");

   a_accept_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.image_accepted == (rsp_data.marker_found
         && rsp_data.identity_match && rsp_data.version_allowed))
      else $error("accept flag inconsistent");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      ccnt_ff <= CW'(CAPTURE_MAX))
      else $error("capture count overflow");

   a_flags_need_marker: assert property (@(posedge clock) disable iff (reset)
      (idf_ff || verf_ff) |-> found_ff)
      else $error("flag set without marker");

endmodule

`default_nettype wire
